[rtl/pfc_pkg.sv]
// pfc_pkg: types and constants shared by the pixel format converter files
// holds stream payload structs, mode and register codes, palette request struct
// no dependencies
package pfc_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE          = 2'd0;
  localparam logic [1:0] CFG_SWAP_RED_BLUE = 2'd1;
  localparam logic [1:0] CFG_COMPONENT     = 2'd2;

  // conversion modes
  localparam logic [3:0] MODE_RGB_TO_RGBA = 4'd0;
  localparam logic [3:0] MODE_IDX_RGBA    = 4'd1;
  localparam logic [3:0] MODE_IDX_GREY    = 4'd2;
  localparam logic [3:0] MODE_RGB_GREY    = 4'd3;
  localparam logic [3:0] MODE_RGBA_RGB    = 4'd4;
  localparam logic [3:0] MODE_SWAP        = 4'd5;
  localparam logic [3:0] MODE_YUV         = 4'd6;
  localparam logic [3:0] MODE_COMP_RGB    = 4'd7;
  localparam logic [3:0] MODE_COMP_IDX    = 4'd8;
  localparam logic [3:0] MODE_IDX_ARGB    = 4'd9;

  // item kinds
  localparam logic FUNC_PALETTE = 1'b0;
  localparam logic FUNC_PIXEL   = 1'b1;

  // component codes
  localparam logic [1:0] COMP_0 = 2'd0;
  localparam logic [1:0] COMP_1 = 2'd1;
  localparam logic [1:0] COMP_2 = 2'd2;

  // grey weights and mean reciprocal (683 / 2048 is exact for sums below 768)
  localparam logic [9:0]  W_RED    = 10'd306;
  localparam logic [9:0]  W_GREEN  = 10'd601;
  localparam logic [9:0]  W_BLUE   = 10'd117;
  localparam logic [9:0]  RECIP_3  = 10'd683;
  localparam logic [7:0]  ALPHA_FF = 8'd255;

  // byte counts
  localparam logic [2:0] CNT_1 = 3'd1;
  localparam logic [2:0] CNT_3 = 3'd3;
  localparam logic [2:0] CNT_4 = 3'd4;

  typedef struct packed {
    logic        func;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
    logic [31:0] pixel_in;
    logic        end_of_image;
  } pfc_in_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic [2:0]  byte_count;
    logic        end_of_image_out;
  } pfc_out_t;

  // request from the top level to the palette memory
  typedef struct packed {
    logic        we;
    logic [7:0]  waddr;
    logic [23:0] wdata;
    logic        re;
    logic [7:0]  raddr;
  } pal_req_t;

endpackage

[rtl/pfc_stream_if.sv]
// pfc_stream_if: valid/ready stream channel with a typed payload
// payload types come from pfc_pkg through the type parameter
interface pfc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/pfc_palette.sv]
// pfc_palette: palette memory, one write and one registered read per cycle
// depends on pfc_pkg for the request struct; out-of-range indexes read as zero
module pfc_palette import pfc_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pal_req_t    req_i,
  output logic [23:0] rdata_o
);

  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [23:0] mem [PALETTE_ENTRIES];
  logic [23:0] rdata_q;
  logic        rd_in_range_q;
  logic        wr_in_range;
  logic        rd_in_range;

  assign wr_in_range = {1'b0, req_i.waddr} < 9'(PALETTE_ENTRIES);
  assign rd_in_range = {1'b0, req_i.raddr} < 9'(PALETTE_ENTRIES);

  // write port, writes beyond the depth are dropped
  always_ff @(posedge clk_i) begin
    if (req_i.we && wr_in_range) begin
      mem[req_i.waddr[IDX_W-1:0]] <= req_i.wdata;
    end
  end

  // registered read port, held while no read is requested
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_in_range_q <= 1'b0;
    end else if (req_i.re) begin
      rd_in_range_q <= rd_in_range;
    end
  end

  assign rdata_o = rd_in_range_q ? rdata_q : 24'd0;

endmodule

[rtl/pixel_format_converter.sv]
// pixel_format_converter: converts one pixel per transfer using a palette memory
// depends on pfc_pkg, pfc_stream_if and pfc_palette
//
// One item is accepted per clock cycle while the output does not stall. A pixel
// result first waits in stage one for its registered palette read; the conversion
// is then computed into the output register. Palette items write the memory in
// the cycle they are accepted and produce no result; a pixel accepted in the next
// cycle already sees the new entry. The palette holds PALETTE_ENTRIES entries of
// 24 bits and is undefined until written; indexes at or above PALETTE_ENTRIES read
// as zero. Configuration (mode, swap_red_blue, component) is to be written by the
// user only while the block is idle; the block itself does not enforce this.
module pixel_format_converter import pfc_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  pfc_stream_if.sink   in_i,
  pfc_stream_if.source out_o
);

  // configuration registers
  logic [3:0] mode_q;
  logic       swap_q;
  logic [1:0] comp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RGB_TO_RGBA;
      swap_q <= 1'b0;
      comp_q <= COMP_0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:          mode_q <= cfg_data_i;
        CFG_SWAP_RED_BLUE: swap_q <= cfg_data_i[0];
        CFG_COMPONENT:     comp_q <= cfg_data_i[1:0];
        default:           ;
      endcase
    end
  end

  // pipeline control
  logic        s1_valid_q;
  logic [31:0] s1_pix_q;
  logic        s1_eoi_q;
  logic        out_valid_q;
  pfc_out_t    out_data_q;
  logic        out_adv;
  logic        in_ready;
  logic        in_xfer;
  logic        pix_xfer;

  assign out_adv  = !out_valid_q || out_o.ready;
  assign in_ready = !s1_valid_q || out_adv;
  assign in_xfer  = in_i.valid && in_ready;
  assign pix_xfer = in_xfer && (in_i.data.func == FUNC_PIXEL);

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // palette memory access
  pal_req_t    pal_req;
  logic [23:0] ent;

  always_comb begin
    pal_req.we    = in_xfer && (in_i.data.func == FUNC_PALETTE);
    pal_req.waddr = in_i.data.palette_index;
    pal_req.wdata = in_i.data.palette_color;
    pal_req.re    = pix_xfer;
    pal_req.raddr = in_i.data.pixel_in[7:0];
  end

  pfc_palette #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_palette (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (pal_req),
    .rdata_o(ent)
  );

  // stage one: pixel waits for its palette read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= pix_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_xfer) begin
      s1_pix_q <= in_i.data.pixel_in;
      s1_eoi_q <= in_i.data.end_of_image;
    end
  end

  // conversion datapath
  logic [7:0]  p0, p1, p2, p3, e0, e1, e2;
  logic [9:0]  ent_sum;
  logic [19:0] mean_prod;
  logic [17:0] grey_sum;
  logic [9:0]  y_sum;
  logic [8:0]  d_u, d_v;
  logic [8:0]  h_u, h_v;
  logic [31:0] res;
  logic [2:0]  cnt;

  assign p0 = s1_pix_q[7:0];
  assign p1 = s1_pix_q[15:8];
  assign p2 = s1_pix_q[23:16];
  assign p3 = s1_pix_q[31:24];
  assign e0 = ent[7:0];
  assign e1 = ent[15:8];
  assign e2 = ent[23:16];

  assign ent_sum   = 10'(e0) + 10'(e1) + 10'(e2);
  assign mean_prod = 20'(ent_sum) * 20'(RECIP_3);
  assign grey_sum  = 18'(p2) * 18'(W_RED) + 18'(p1) * 18'(W_GREEN) + 18'(p0) * 18'(W_BLUE);
  assign y_sum     = 10'(p2) + {1'b0, p1, 1'b0} + 10'(p0);

  // halving toward zero: add one to negative differences before the shift
  assign d_u = 9'(p0) - 9'(p1);
  assign d_v = 9'(p2) - 9'(p1);
  assign h_u = $signed(d_u + 9'(d_u[8])) >>> 1;
  assign h_v = $signed(d_v + 9'(d_v[8])) >>> 1;

  always_comb begin
    res = s1_pix_q;
    cnt = CNT_4;
    unique case (mode_q)
      MODE_RGB_TO_RGBA: begin
        res = {ALPHA_FF, p2, p1, p0};
        cnt = CNT_4;
      end
      MODE_IDX_RGBA: begin
        res = {ALPHA_FF, e2, e1, e0};
        cnt = CNT_4;
      end
      MODE_IDX_GREY: begin
        res = {24'd0, mean_prod[18:11]};
        cnt = CNT_1;
      end
      MODE_RGB_GREY: begin
        res = {24'd0, grey_sum[17:10]};
        cnt = CNT_1;
      end
      MODE_RGBA_RGB: begin
        res = swap_q ? {8'd0, p0, p1, p2} : {8'd0, p2, p1, p0};
        cnt = CNT_3;
      end
      MODE_SWAP: begin
        res = {p3, p0, p1, p2};
        cnt = CNT_4;
      end
      MODE_YUV: begin
        res = {8'd0, h_v[7:0], h_u[7:0], y_sum[9:2]};
        cnt = CNT_3;
      end
      MODE_COMP_RGB: begin
        unique case (comp_q)
          COMP_0:  res = {24'd0, p0};
          COMP_1:  res = {24'd0, p1};
          COMP_2:  res = {24'd0, p2};
          default: res = 32'd0;
        endcase
        cnt = CNT_1;
      end
      MODE_COMP_IDX: begin
        unique case (comp_q)
          COMP_0:  res = {24'd0, e2};
          COMP_1:  res = {24'd0, e1};
          COMP_2:  res = {24'd0, e0};
          default: res = 32'd0;
        endcase
        cnt = CNT_1;
      end
      MODE_IDX_ARGB: begin
        res = {ALPHA_FF, e0, e1, e2};
        cnt = CNT_4;
      end
      default: begin
        res = s1_pix_q;
        cnt = CNT_4;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_data_q.pixel_out        <= res;
      out_data_q.byte_count       <= cnt;
      out_data_q.end_of_image_out <= s1_eoi_q;
    end
  end

`ifndef SYNTH
  // a full pipeline with a stalled output takes no new item
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while pipeline is full and stalled");

  // an accepted pixel occupies stage one in the next cycle
  a_pixel_enters_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_xfer |=> s1_valid_q)
    else $error("accepted pixel lost before stage one");

  // a palette item never fills stage one
  a_palette_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.data.func == FUNC_PALETTE) |=> !s1_valid_q)
    else $error("palette item entered the result path");

  // every delivered result carries one, three or four bytes
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.byte_count == CNT_1 || out_data_q.byte_count == CNT_3
                     || out_data_q.byte_count == CNT_4))
    else $error("byte count out of range");
`endif

endmodule
